// ===== hw/rtl/s2rgb_pkg.sv =====
// Shared widths, register codes, colour tables and helpers of the colour ramp.
package s2rgb_pkg;

   // Arithmetic widths.
   localparam int VALUE_BITS    = 32;
   localparam int FRACTION_BITS = 16;
   localparam int FIELD_BITS    = 32;
   localparam int T_BITS        = FRACTION_BITS + 1;
   localparam int QUO_STEPS     = FRACTION_BITS + 1;
   localparam int CHANNELS      = 3;
   localparam int COLOUR_BITS   = 8;
   localparam int RGB_BITS      = CHANNELS * COLOUR_BITS;
   localparam int PROD_BITS     = COLOUR_BITS + T_BITS;
   localparam int NUM_BITS      = T_BITS + COLOUR_BITS;
   localparam int DIV_BITS      = T_BITS + 1;
   localparam int MILLI_BITS    = 10;

   // Register port.
   localparam int CSR_DATA_BITS = 32;
   localparam int ADDR_BITS     = 4;
   localparam int REG_BITS      = ADDR_BITS - 2;
   localparam logic [1:0]            MAP_MODE_RESET   = 2'd0;
   localparam logic [FIELD_BITS-1:0] RANGE_LOW_RESET  = 32'd0;
   localparam logic [FIELD_BITS-1:0] RANGE_HIGH_RESET = 32'd65535;

   typedef enum logic [REG_BITS-1:0] {
      REG_MAP_MODE   = 2'd0,
      REG_RANGE_LOW  = 2'd1,
      REG_RANGE_HIGH = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_GRAY    = 2'd0,
      MODE_VIRIDIS = 2'd1,
      MODE_TURBO   = 2'd2
   } map_mode_type;

   // Colour stops; channel 0 is red.
   typedef logic [COLOUR_BITS-1:0] colour_type;
   typedef colour_type [CHANNELS-1:0] rgb_type;

   typedef struct packed {
      logic [MILLI_BITS-1:0] milli;
      rgb_type               rgb;
   } stop_type;

   localparam int VIRIDIS_STOPS = 7;
   localparam int TURBO_STOPS   = 8;
   localparam int SEG_BITS      = $clog2(TURBO_STOPS);

   function automatic stop_type make_stop(input logic [MILLI_BITS-1:0] milli,
                                          input colour_type r, input colour_type g,
                                          input colour_type b);
      stop_type s;
      s.milli = milli;
      s.rgb   = {b, g, r};
      return s;
   endfunction

   localparam stop_type VIRIDIS [VIRIDIS_STOPS] = '{
      make_stop(10'd0,    8'd68,  8'd1,   8'd84),
      make_stop(10'd167,  8'd65,  8'd68,  8'd135),
      make_stop(10'd333,  8'd42,  8'd120, 8'd142),
      make_stop(10'd500,  8'd34,  8'd168, 8'd132),
      make_stop(10'd667,  8'd122, 8'd209, 8'd81),
      make_stop(10'd833,  8'd189, 8'd223, 8'd38),
      make_stop(10'd1000, 8'd253, 8'd231, 8'd37)
   };

   localparam stop_type TURBO [TURBO_STOPS] = '{
      make_stop(10'd0,    8'd48,  8'd18,  8'd59),
      make_stop(10'd143,  8'd64,  8'd116, 8'd240),
      make_stop(10'd286,  8'd30,  8'd184, 8'd199),
      make_stop(10'd429,  8'd76,  8'd220, 8'd99),
      make_stop(10'd571,  8'd191, 8'd211, 8'd47),
      make_stop(10'd714,  8'd251, 8'd162, 8'd44),
      make_stop(10'd857,  8'd230, 8'd79,  8'd21),
      make_stop(10'd1000, 8'd122, 8'd4,   8'd3)
   };

   // Stop position in thousandths to fixed point, rounding halves up.
   function automatic logic [T_BITS-1:0] stop_pos(input logic [MILLI_BITS-1:0] milli);
      logic [MILLI_BITS+FRACTION_BITS:0] wide;
      wide = ((MILLI_BITS + FRACTION_BITS + 1)'(milli) << FRACTION_BITS) +
             (MILLI_BITS + FRACTION_BITS + 1)'(500);
      return T_BITS'(wide / 1000);
   endfunction

   // Stop positions in fixed point, worked out once from the tables.
   localparam logic [T_BITS-1:0] VIRIDIS_POS [VIRIDIS_STOPS] = '{
      stop_pos(VIRIDIS[0].milli), stop_pos(VIRIDIS[1].milli), stop_pos(VIRIDIS[2].milli),
      stop_pos(VIRIDIS[3].milli), stop_pos(VIRIDIS[4].milli), stop_pos(VIRIDIS[5].milli),
      stop_pos(VIRIDIS[6].milli)
   };

   localparam logic [T_BITS-1:0] TURBO_POS [TURBO_STOPS] = '{
      stop_pos(TURBO[0].milli), stop_pos(TURBO[1].milli), stop_pos(TURBO[2].milli),
      stop_pos(TURBO[3].milli), stop_pos(TURBO[4].milli), stop_pos(TURBO[5].milli),
      stop_pos(TURBO[6].milli), stop_pos(TURBO[7].milli)
   };

   // Field to working value: low bits kept, bits above the field read as zero.
   function automatic logic signed [VALUE_BITS-1:0] to_value(
         input logic [FIELD_BITS-1:0] x);
      logic [VALUE_BITS+FIELD_BITS-1:0] wide;
      wide = {{VALUE_BITS{1'b0}}, x};
      return wide[VALUE_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/scalar_to_rgb_colormap.sv =====
// Top level of the scalar to RGB colour ramp.

// One signed sample per beat is mapped to an 8-bit RGB colour and an opacity flag.
// The sample is normalised against the range registers to t in [0,1] with
// FRACTION_BITS fraction bits, then shaded as grey or along the viridis or turbo
// ramp; a missing sample or an empty range gives transparent black. A new beat is
// taken every clock while req_tready is high, and each result passes through one
// register stage per quotient bit of the normalising division (FRACTION_BITS + 1),
// one per bit of the colour interpolation division, and the input, rounding, segment,
// multiply, divider entry and output registers. A two-entry output buffer holds
// results while the consumer stalls, and req_tready drops only while that buffer is
// full. Write registers only while the block holds no work.
module scalar_to_rgb_colormap (
   input  logic                                 clock,
   input  logic                                 reset,
   // Sample stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [s2rgb_pkg::FIELD_BITS-1:0]     req_tdata,  // [31:0] sample_value
   input  logic                                 req_tuser,  // [0] sample_invalid
   // Colour stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [s2rgb_pkg::RGB_BITS-1:0]       rsp_tdata,  // [7:0] red, [15:8] green,
                                                            // [23:16] blue
   output logic                                 rsp_tuser,  // [0] opaque
   // Register port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [s2rgb_pkg::ADDR_BITS-1:0]      csr_paddr,
   input  logic [s2rgb_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [s2rgb_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import s2rgb_pkg::*;

   // Normalising divider stage.
   typedef struct packed {
      logic [VALUE_BITS-1:0] rem;
      logic [QUO_STEPS-1:0]  quo;
      logic [VALUE_BITS-1:0] den;
      logic                  kill;
      logic                  lt;
      logic                  ge;
   } div_type;

   typedef struct packed {
      logic [T_BITS-1:0] t;
      logic              kill;
   } norm_type;

   typedef struct packed {
      rgb_type           a;
      rgb_type           b;
      logic [T_BITS-1:0] span;
      logic [T_BITS-1:0] off;
      logic [T_BITS-1:0] rest;
      logic              kill;
   } seg_type;

   typedef struct packed {
      logic [CHANNELS-1:0][PROD_BITS-1:0] pa;
      logic [CHANNELS-1:0][PROD_BITS-1:0] pb;
      logic [T_BITS-1:0]                  span;
      logic                               kill;
   } mul_type;

   // Colour interpolation divider stage.
   typedef struct packed {
      logic [CHANNELS-1:0][NUM_BITS-1:0] rem;
      rgb_type                           quo;
      logic [DIV_BITS-1:0]               den;
      logic                              kill;
   } cdiv_type;

   typedef struct packed {
      rgb_type rgb;
      logic    opaque;
   } res_type;

   // Registers of the configuration port.
   logic [1:0]            mode_ff, mode_in;
   logic [FIELD_BITS-1:0] range_low_ff, range_low_in;
   logic [FIELD_BITS-1:0] range_high_ff, range_high_in;
   reg_index_type         csr_index;
   logic                  csr_write;

   // Pipeline registers.
   logic                   adv;
   div_type                div_ff [QUO_STEPS+1];
   div_type                div_in [QUO_STEPS+1];
   logic [QUO_STEPS:0]     dvld_ff, dvld_in;
   norm_type               norm_ff, norm_in;
   logic                   nvld_ff;
   seg_type                seg_ff, seg_in;
   logic                   svld_ff;
   mul_type                mul_ff, mul_in;
   logic                   mvld_ff;
   cdiv_type               cdiv_ff [COLOUR_BITS+1];
   cdiv_type               cdiv_in [COLOUR_BITS+1];
   logic [COLOUR_BITS:0]   cvld_ff, cvld_in;
   logic                   last_vld;
   res_type                last_res;

   // Output register and skid entry.
   res_type out_ff, out_in, skid_ff, skid_in;
   logic    out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic    take;

   // Register writes and reads.
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_BITS-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      mode_in       = mode_ff;
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MAP_MODE:   mode_in       = csr_pwdata[1:0];
            REG_RANGE_LOW:  range_low_in  = csr_pwdata[FIELD_BITS-1:0];
            REG_RANGE_HIGH: range_high_in = csr_pwdata[FIELD_BITS-1:0];
            default:        mode_in       = mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MAP_MODE:   csr_prdata = CSR_DATA_BITS'(mode_ff);
         REG_RANGE_LOW:  csr_prdata = CSR_DATA_BITS'(range_low_ff);
         REG_RANGE_HIGH: csr_prdata = CSR_DATA_BITS'(range_high_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MAP_MODE_RESET;
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else begin
         mode_ff       <= mode_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

   // The whole pipeline moves while the skid entry is free.
   assign adv        = ~skid_vld_ff;
   assign req_tready = adv;

   // Entry stage and one restoring division step per stage.
   always_comb begin
      logic signed [VALUE_BITS-1:0] v, lo, hi;
      logic [VALUE_BITS:0]          sh;
      v  = to_value(req_tdata);
      lo = to_value(range_low_ff);
      hi = to_value(range_high_ff);
      div_in[0].rem  = VALUE_BITS'(v - lo);
      div_in[0].quo  = '0;
      div_in[0].den  = VALUE_BITS'(hi - lo);
      div_in[0].kill = req_tuser | (hi <= lo);
      div_in[0].lt   = v <= lo;
      div_in[0].ge   = v >= hi;
      dvld_in[0]     = req_tvalid;
      for (int k = 1; k <= QUO_STEPS; k++) begin
         div_in[k] = div_ff[k-1];
         dvld_in[k] = dvld_ff[k-1];
         sh = {div_ff[k-1].rem, 1'b0};
         if (sh >= {1'b0, div_ff[k-1].den}) begin
            div_in[k].rem = VALUE_BITS'(sh - {1'b0, div_ff[k-1].den});
            div_in[k].quo = {div_ff[k-1].quo[QUO_STEPS-2:0], 1'b1};
         end else begin
            div_in[k].rem = sh[VALUE_BITS-1:0];
            div_in[k].quo = {div_ff[k-1].quo[QUO_STEPS-2:0], 1'b0};
         end
      end
   end

   // Rounded and clamped ramp position.
   always_comb begin
      logic [QUO_STEPS:0] q1;
      q1 = {1'b0, div_ff[QUO_STEPS].quo} + 1'b1;
      norm_in.kill = div_ff[QUO_STEPS].kill;
      priority if (div_ff[QUO_STEPS].lt) begin
         norm_in.t = '0;
      end else if (div_ff[QUO_STEPS].ge) begin
         norm_in.t = T_BITS'(1) << FRACTION_BITS;
      end else begin
         norm_in.t = q1[QUO_STEPS:1];
      end
   end

   // Segment choice: end colours, span and offset of the segment that holds t.
   function automatic seg_type make_seg(input rgb_type a, input rgb_type b,
                                        input logic [T_BITS-1:0] lo_pos,
                                        input logic [T_BITS-1:0] hi_pos,
                                        input logic [T_BITS-1:0] t);
      seg_type s;
      s.a    = a;
      s.b    = b;
      s.span = hi_pos - lo_pos;
      s.kill = 1'b0;
      priority if (t <= lo_pos) begin
         s.off = '0;
      end else if (t >= hi_pos) begin
         s.off = s.span;
      end else begin
         s.off = t - lo_pos;
      end
      s.rest = s.span - s.off;
      return s;
   endfunction

   always_comb begin
      logic [SEG_BITS-1:0] vsel, vprev, tsel, tprev;
      logic [T_BITS-1:0]   t;
      t    = norm_ff.t;
      vsel = SEG_BITS'(VIRIDIS_STOPS - 1);
      for (int i = VIRIDIS_STOPS - 1; i >= 1; i--) begin
         if (t <= VIRIDIS_POS[i]) vsel = SEG_BITS'(i);
      end
      tsel = SEG_BITS'(TURBO_STOPS - 1);
      for (int i = TURBO_STOPS - 1; i >= 1; i--) begin
         if (t <= TURBO_POS[i]) tsel = SEG_BITS'(i);
      end
      vprev = vsel - SEG_BITS'(1);
      tprev = tsel - SEG_BITS'(1);
      unique case (mode_ff)
         MODE_VIRIDIS: begin
            seg_in = make_seg(VIRIDIS[vprev].rgb, VIRIDIS[vsel].rgb,
                              VIRIDIS_POS[vprev], VIRIDIS_POS[vsel], t);
         end
         MODE_TURBO: begin
            seg_in = make_seg(TURBO[tprev].rgb, TURBO[tsel].rgb,
                              TURBO_POS[tprev], TURBO_POS[tsel], t);
         end
         default: begin
            // Grey is one segment from black to white over the whole range.
            seg_in = make_seg('0, '1, '0, T_BITS'(1) << FRACTION_BITS, t);
         end
      endcase
      seg_in.kill = norm_ff.kill;
   end

   // Weighted end colours: a * (span - off) and b * off.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         mul_in.pa[c] = PROD_BITS'(seg_ff.a[c]) * PROD_BITS'(seg_ff.rest);
         mul_in.pb[c] = PROD_BITS'(seg_ff.b[c]) * PROD_BITS'(seg_ff.off);
      end
      mul_in.span = seg_ff.span;
      mul_in.kill = seg_ff.kill;
   end

   // Rounded quotient (2n + span) / (2 span), one bit per stage.
   always_comb begin
      logic [NUM_BITS-1:0] n, dsh;
      for (int c = 0; c < CHANNELS; c++) begin
         n = NUM_BITS'(mul_ff.pa[c]) + NUM_BITS'(mul_ff.pb[c]);
         cdiv_in[0].rem[c] = (n << 1) + NUM_BITS'(mul_ff.span);
      end
      cdiv_in[0].quo  = '0;
      cdiv_in[0].den  = {mul_ff.span, 1'b0};
      cdiv_in[0].kill = mul_ff.kill;
      cvld_in[0]      = mvld_ff;
      for (int j = 1; j <= COLOUR_BITS; j++) begin
         cdiv_in[j] = cdiv_ff[j-1];
         cvld_in[j] = cvld_ff[j-1];
         dsh = NUM_BITS'(cdiv_ff[j-1].den) << (COLOUR_BITS - j);
         for (int c = 0; c < CHANNELS; c++) begin
            if (cdiv_ff[j-1].rem[c] >= dsh) begin
               cdiv_in[j].rem[c] = cdiv_ff[j-1].rem[c] - dsh;
               cdiv_in[j].quo[c] = {cdiv_ff[j-1].quo[c][COLOUR_BITS-2:0], 1'b1};
            end else begin
               cdiv_in[j].quo[c] = {cdiv_ff[j-1].quo[c][COLOUR_BITS-2:0], 1'b0};
            end
         end
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
         nvld_ff <= 1'b0;
         svld_ff <= 1'b0;
         mvld_ff <= 1'b0;
         cvld_ff <= '0;
      end else if (adv) begin
         dvld_ff <= dvld_in;
         nvld_ff <= dvld_ff[QUO_STEPS];
         svld_ff <= nvld_ff;
         mvld_ff <= svld_ff;
         cvld_ff <= cvld_in;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff  <= div_in;
         norm_ff <= norm_in;
         seg_ff  <= seg_in;
         mul_ff  <= mul_in;
         cdiv_ff <= cdiv_in;
      end
   end

   // An invalid sample or empty range leaves transparent black.
   assign last_vld        = cvld_ff[COLOUR_BITS];
   assign last_res.rgb    = cdiv_ff[COLOUR_BITS].kill ? '0 : cdiv_ff[COLOUR_BITS].quo;
   assign last_res.opaque = ~cdiv_ff[COLOUR_BITS].kill;

   // Output register with a skid entry behind it.
   assign take = out_vld_ff & rsp_tready;

   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      priority if (skid_vld_ff) begin
         if (take) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (out_vld_ff && !take) begin
         if (last_vld) begin
            skid_in     = last_res;
            skid_vld_in = 1'b1;
         end
      end else begin
         out_in     = last_res;
         out_vld_in = last_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.rgb;
   assign rsp_tuser  = out_ff.opaque;

`ifndef SYNTHESIS
   // The skid entry fills only behind a held output beat.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry full while output register is empty");

   // A transparent beat carries black.
   a_transparent_black: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ff.opaque) |-> (out_ff.rgb == '0))
      else $error("transparent beat with a non-black colour");

   // A result arriving behind a stalled output beat is parked, not dropped.
   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_tready && !skid_vld_ff && last_vld) |=> skid_vld_ff)
      else $error("result lost behind a stalled output beat");
`endif

endmodule
